// ===== hw/rtl/mss_pkg.sv =====
// Shared types and constants for the multi-stack shared store.
// Holds the operation and result codes and the controller/datapath link structs.
// No dependencies.
package mss_pkg;

    // Fixed port widths
    localparam int PORT_DATA_W = 64;
    localparam int ID_W        = 4;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int CFG_W       = 4;

    // Operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH = 2'd0,
        KIND_POP  = 2'd1,
        KIND_LIST = 2'd2,
        KIND_NOP  = 2'd3
    } t_kind;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED     = 3'd0,
        ST_POPPED     = 3'd1,
        ST_FULL       = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_BAD_ID     = 3'd4,
        ST_LISTED     = 3'd5,
        ST_LIST_EMPTY = 3'd6
    } t_status;

    // Result data source
    typedef enum logic [1:0] {
        DSEL_ZERO    = 2'd0,
        DSEL_PAYLOAD = 2'd1,
        DSEL_RAM     = 2'd2
    } t_dsel;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    push;
        logic    pop;
        logic    list_first;
        logic    list_next;
        logic    emit;
        t_status code;
        logic    emit_last;
        t_dsel   dsel;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_kind kind;
        logic  bad_id;
        logic  full;
        logic  empty;
        logic  idx_zero;
    } t_dp_stat;

endpackage

// ===== hw/rtl/mss_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module mss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 10,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mss_ctrl.sv =====
// Controller state machine for the multi-stack shared store.
// Depends on mss_pkg; drives the datapath through t_dp_cmd and reads t_dp_stat.
module mss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  mss_pkg::t_dp_stat i_stat,
    output mss_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);
    import mss_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_POP  = 4'b0100,
        S_LIST = 4'b1000
    } t_state;

    t_state   r_state, n_state;
    t_dp_cmd  w_cmd;

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        w_cmd          = '0;
        w_cmd.code     = ST_PUSHED;
        w_cmd.dsel     = DSEL_ZERO;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
                if (i_stat.kind == KIND_NOP) begin
                    n_state = S_IDLE;
                end else if (i_stat.bad_id) begin
                    w_cmd.emit      = 1'b1;
                    w_cmd.emit_last = 1'b1;
                    w_cmd.code      = ST_BAD_ID;
                end else begin
                    case (i_stat.kind)
                        KIND_PUSH: begin
                            w_cmd.emit      = 1'b1;
                            w_cmd.emit_last = 1'b1;
                            if (i_stat.full) begin
                                w_cmd.code = ST_FULL;
                            end else begin
                                w_cmd.push = 1'b1;
                                w_cmd.code = ST_PUSHED;
                                w_cmd.dsel = DSEL_PAYLOAD;
                            end
                        end
                        KIND_POP: begin
                            if (i_stat.empty) begin
                                w_cmd.emit      = 1'b1;
                                w_cmd.emit_last = 1'b1;
                                w_cmd.code      = ST_EMPTY;
                            end else begin
                                w_cmd.pop = 1'b1;
                                n_state   = S_POP;
                            end
                        end
                        KIND_LIST: begin
                            if (i_stat.empty) begin
                                w_cmd.emit      = 1'b1;
                                w_cmd.emit_last = 1'b1;
                                w_cmd.code      = ST_LIST_EMPTY;
                            end else begin
                                w_cmd.list_first = 1'b1;
                                n_state          = S_LIST;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_POP: begin
                w_cmd.emit      = 1'b1;
                w_cmd.emit_last = 1'b1;
                w_cmd.code      = ST_POPPED;
                w_cmd.dsel      = DSEL_RAM;
                n_state         = S_IDLE;
            end
            S_LIST: begin
                w_cmd.emit      = 1'b1;
                w_cmd.emit_last = i_stat.idx_zero;
                w_cmd.code      = ST_LISTED;
                w_cmd.dsel      = DSEL_RAM;
                if (i_stat.idx_zero) begin
                    n_state = S_IDLE;
                end else begin
                    w_cmd.list_next = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = w_cmd;
    assign o_busy = (r_state != S_IDLE);

    // A pop result always follows the evaluation cycle
    a_pop_after_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> ($past(r_state) == S_EVAL))
        else $error("pop output without evaluation");

    // A listing keeps walking until the bottom entry
    a_list_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST && !i_stat.idx_zero) |=> (r_state == S_LIST))
        else $error("listing stopped early");

    // The final result of a transaction returns the controller to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_cmd.emit_last) |=> (r_state == S_IDLE))
        else $error("busy after final result");

    // Never push to a bad id or a full stack, nor pop a bad id or an empty one
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.push || w_cmd.pop) |->
            !i_stat.bad_id && !(w_cmd.push && i_stat.full) && !(w_cmd.pop && i_stat.empty))
        else $error("stack overrun or underrun");

endmodule

// ===== hw/rtl/mss_dp.sv =====
// Datapath for the multi-stack shared store: partition register and lookup,
// fill-count RAM with valid bits, entry RAM, address arithmetic and result registers.
// Depends on mss_pkg and mss_ram.
module mss_dp #(
    parameter int TOTAL_ENTRIES = 10,
    parameter int MAX_STACKS    = 10,
    parameter int ENTRY_BITS    = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mss_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic [mss_pkg::KIND_W-1:0]       i_kind,
    input  logic [mss_pkg::ID_W-1:0]         i_stack_id,
    input  logic [mss_pkg::PORT_DATA_W-1:0]  i_payload,
    input  mss_pkg::t_dp_cmd                 i_cmd,
    output mss_pkg::t_dp_stat                o_stat,
    output logic                             o_valid,
    output logic [mss_pkg::STATUS_W-1:0]     o_status,
    output logic [mss_pkg::ID_W-1:0]         o_stack_echo,
    output logic [mss_pkg::PORT_DATA_W-1:0]  o_entry_data,
    output logic                             o_last
);
    import mss_pkg::*;

    localparam int AW  = $clog2(TOTAL_ENTRIES);
    localparam int FW  = $clog2(TOTAL_ENTRIES + 1);
    localparam int SW  = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int CW  = $clog2(MAX_STACKS + 1);
    localparam int IW  = (CW > ID_W) ? CW : ID_W;
    localparam int PW  = ID_W + FW;
    localparam int NLUT = 1 << CFG_W;

    // Partition lookup per register value
    logic [FW-1:0] w_slice_lut [NLUT];
    logic [CW-1:0] w_count_lut [NLUT];
    logic [FW-1:0] w_lcap_lut  [NLUT];

    for (genvar g = 0; g < NLUT; g++) begin : g_lut
        localparam int NR  = (g == 0) ? 1 : ((g > TOTAL_ENTRIES) ? TOTAL_ENTRIES : g);
        localparam int SL  = TOTAL_ENTRIES / NR;
        localparam int C0  = TOTAL_ENTRIES / SL;
        localparam int CNT = (C0 > MAX_STACKS) ? MAX_STACKS : C0;
        localparam int LC  = TOTAL_ENTRIES - (CNT - 1) * SL;
        assign w_slice_lut[g] = FW'(SL);
        assign w_count_lut[g] = CW'(CNT);
        assign w_lcap_lut[g]  = FW'(LC);
    end

    logic [CFG_W-1:0]      r_req;
    logic [MAX_STACKS-1:0] r_fill_vld;
    logic [KIND_W-1:0]     r_kind;
    logic [ID_W-1:0]       r_id;
    logic [ENTRY_BITS-1:0] r_payload;
    logic [FW-1:0]         r_idx;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [ID_W-1:0]       r_out_echo;
    logic [PORT_DATA_W-1:0] r_out_data;
    logic                  r_out_last;

    logic [FW-1:0]         w_slice;
    logic [CW-1:0]         w_count;
    logic [FW-1:0]         w_lcap;
    logic [IW-1:0]         w_id_ext;
    logic [IW-1:0]         w_in_id_ext;
    logic [SW-1:0]         w_id_idx;
    logic [SW-1:0]         w_fill_raddr;
    logic [FW-1:0]         w_fill_rd;
    logic [FW-1:0]         w_fill;
    logic [FW-1:0]         w_cap;
    logic                  w_fill_we;
    logic [FW-1:0]         w_fill_wd;
    logic [PW-1:0]         w_base;
    logic [PW-1:0]         w_top;
    logic [FW-1:0]         w_off;
    logic [PW-1:0]         w_rd_sum;
    logic [ENTRY_BITS-1:0] w_entry_rd;

    assign w_slice = w_slice_lut[r_req];
    assign w_count = w_count_lut[r_req];
    assign w_lcap  = w_lcap_lut[r_req];

    // Stack index into the fill store
    assign w_id_ext     = IW'(r_id);
    assign w_in_id_ext  = IW'(i_stack_id);
    assign w_id_idx     = w_id_ext[SW-1:0];
    assign w_fill_raddr = i_cmd.load ? w_in_id_ext[SW-1:0] : w_id_idx;

    // Fill count reads as zero until written since the last clear
    assign w_fill = r_fill_vld[w_id_idx] ? w_fill_rd : '0;
    assign w_cap  = (w_id_ext + IW'(1) == IW'(w_count)) ? w_lcap : w_slice;

    // Fill count update
    assign w_fill_we = i_cmd.push || i_cmd.pop;
    assign w_fill_wd = i_cmd.push ? (w_fill + FW'(1)) : (w_fill - FW'(1));

    // Entry addresses: push at base + fill, reads at base + offset - 1
    assign w_base   = PW'(r_id) * PW'(w_slice);
    assign w_top    = w_base + PW'(w_fill);
    assign w_off    = i_cmd.list_next ? r_idx : w_fill;
    assign w_rd_sum = w_base + PW'(w_off) - PW'(1);

    mss_ram #(
        .WIDTH (FW),
        .DEPTH (MAX_STACKS),
        .AW    (SW)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (w_fill_we),
        .i_waddr (w_id_idx),
        .i_wdata (w_fill_wd),
        .i_raddr (w_fill_raddr),
        .o_rdata (w_fill_rd)
    );

    mss_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TOTAL_ENTRIES),
        .AW    (AW)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (w_top[AW-1:0]),
        .i_wdata (r_payload),
        .i_raddr (w_rd_sum[AW-1:0]),
        .o_rdata (w_entry_rd)
    );

    // Status toward the controller
    assign o_stat.kind     = t_kind'(r_kind);
    assign o_stat.bad_id   = (w_id_ext >= IW'(w_count));
    assign o_stat.full     = (w_fill >= w_cap);
    assign o_stat.empty    = (w_fill == '0);
    assign o_stat.idx_zero = (r_idx == '0);

    // Control registers: partition select, valid bits, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req       <= CFG_W'(1);
            r_fill_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_req      <= i_cfg_data;
                r_fill_vld <= '0;
            end else if (w_fill_we) begin
                r_fill_vld[w_id_idx] <= 1'b1;
            end
            r_out_valid <= i_cmd.emit;
        end
    end

    // Capture the transaction, walk the listing, load the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_kind;
            r_id      <= i_stack_id;
            r_payload <= i_payload[ENTRY_BITS-1:0];
        end
        if (i_cmd.list_first || i_cmd.list_next) begin
            r_idx <= w_off - FW'(1);
        end
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.code;
            r_out_echo   <= r_id;
            r_out_last   <= i_cmd.emit_last;
            case (i_cmd.dsel)
                DSEL_PAYLOAD: r_out_data <= PORT_DATA_W'(r_payload);
                DSEL_RAM:     r_out_data <= PORT_DATA_W'(w_entry_rd);
                default:      r_out_data <= '0;
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_stack_echo = r_out_echo;
    assign o_entry_data = r_out_data;
    assign o_last       = r_out_last;

endmodule

// ===== hw/rtl/multi_stack_shared_store_top.sv =====
// Multi-stack shared store: push, full, bad id and the empty cases are decided in the evaluate
// state and strobe from the result register; pop reads the entry RAM and strobes from the pop state;
// a list strobes one result per cycle from the list state, top entry first, last flag on the bottom.
// Sequencing follows the registered reads of the fill-count RAM and the entry RAM; start is taken only in idle.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// Sync active-low reset and a configuration write empty every stack; reset selects one stack.
module multi_stack_shared_store_top #(
    parameter int TOTAL_ENTRIES = 10,
    parameter int MAX_STACKS    = 10,
    parameter int ENTRY_BITS    = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mss_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             start,
    output logic                             busy,
    input  logic [mss_pkg::KIND_W-1:0]       i_kind,
    input  logic [mss_pkg::ID_W-1:0]         i_stack_id,
    input  logic [mss_pkg::PORT_DATA_W-1:0]  i_payload,
    output logic                             o_valid,
    output logic [mss_pkg::STATUS_W-1:0]     o_status,
    output logic [mss_pkg::ID_W-1:0]         o_stack_echo,
    output logic [mss_pkg::PORT_DATA_W-1:0]  o_entry_data,
    output logic                             o_last
);
    import mss_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    mss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    mss_dp #(
        .TOTAL_ENTRIES (TOTAL_ENTRIES),
        .MAX_STACKS    (MAX_STACKS),
        .ENTRY_BITS    (ENTRY_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_kind       (i_kind),
        .i_stack_id   (i_stack_id),
        .i_payload    (i_payload),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_stack_echo (o_stack_echo),
        .o_entry_data (o_entry_data),
        .o_last       (o_last)
    );

endmodule

// ===== tb/sv/multi_stack_shared_store_top_tb.sv =====
// Testbench for multi_stack_shared_store_top: drives push, pop and list commands and checks
// every result strobe against a shadow copy of the stacks. Depends on mss_pkg and the top.
`timescale 1ns / 100ps

module multi_stack_shared_store_top_tb;
    import mss_pkg::*;

    localparam int TOTAL_ENTRIES = 10;
    localparam int MAX_STACKS    = 10;
    localparam int ENTRY_BITS    = 64;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 22;

    // Stack counts asked for, one per random phase; covers 0, 1, 10 and above 10
    localparam logic [CFG_W-1:0] STACK_SETTINGS [16] = '{
        4'd10, 4'd3, 4'd0, 4'd15, 4'd4, 4'd7, 4'd1, 4'd12,
        4'd6, 4'd5, 4'd2, 4'd9, 4'd8, 4'd11, 4'd13, 4'd14
    };

    typedef struct {
        t_status                status;
        logic [ID_W-1:0]        echo;
        logic [PORT_DATA_W-1:0] data;
        logic                   last;
    } t_stack_result;

    // Shadow of the partitioned stacks plus the results still owed by the block
    class t_stack_mirror;
        logic [PORT_DATA_W-1:0] entries [TOTAL_ENTRIES];
        int unsigned            fill_of [MAX_STACKS];
        int unsigned            slice;
        int unsigned            stack_count;
        t_stack_result          owed_results [$];
        int                     mismatches;

        function new();
            foreach (entries[k]) entries[k] = '0;
            mismatches = 0;
            repartition(4'd1);
        endfunction

        // Rebuild the partition and empty every stack
        function void repartition(logic [CFG_W-1:0] requested);
            int unsigned n;
            n = requested;
            if (n == 0) n = 1;
            if (n > TOTAL_ENTRIES) n = TOTAL_ENTRIES;
            slice = TOTAL_ENTRIES / n;
            stack_count = TOTAL_ENTRIES / slice;
            if (stack_count > MAX_STACKS) stack_count = MAX_STACKS;
            foreach (fill_of[k]) fill_of[k] = 0;
        endfunction

        function int unsigned capacity(int unsigned k);
            if (k + 1 == stack_count) return TOTAL_ENTRIES - k * slice;
            return slice;
        endfunction

        function void owe(t_status st, logic [ID_W-1:0] id, logic [PORT_DATA_W-1:0] data,
                          logic last);
            t_stack_result r;
            r.status = st;
            r.echo   = id;
            r.data   = data;
            r.last   = last;
            owed_results.push_back(r);
        endfunction

        // Apply one accepted command and queue the results it causes
        function void note_item(t_kind kind, logic [ID_W-1:0] id,
                                logic [PORT_DATA_W-1:0] payload);
            int unsigned base;
            int unsigned fill;
            if (kind == KIND_NOP) return;
            if (id >= stack_count) begin
                owe(ST_BAD_ID, id, '0, 1'b1);
                return;
            end
            base = id * slice;
            fill = fill_of[id];
            case (kind)
                KIND_PUSH: begin
                    if (fill >= capacity(id)) begin
                        owe(ST_FULL, id, '0, 1'b1);
                    end else begin
                        entries[(base + fill) % TOTAL_ENTRIES] = payload;
                        fill_of[id] = fill + 1;
                        owe(ST_PUSHED, id, payload, 1'b1);
                    end
                end
                KIND_POP: begin
                    if (fill == 0) begin
                        owe(ST_EMPTY, id, '0, 1'b1);
                    end else begin
                        fill_of[id] = fill - 1;
                        owe(ST_POPPED, id, entries[(base + fill - 1) % TOTAL_ENTRIES], 1'b1);
                    end
                end
                default: begin
                    // List walks top to bottom, last flag on the bottom entry
                    if (fill == 0) begin
                        owe(ST_LIST_EMPTY, id, '0, 1'b1);
                    end else begin
                        for (int unsigned i = fill; i > 0; i--)
                            owe(ST_LISTED, id, entries[(base + i - 1) % TOTAL_ENTRIES], i == 1);
                    end
                end
            endcase
        endfunction

        // Compare one strobed result with the oldest owed result
        function void check_result(logic [STATUS_W-1:0] st, logic [ID_W-1:0] echo,
                                   logic [PORT_DATA_W-1:0] data, logic last);
            t_stack_result want;
            if (owed_results.size() == 0) begin
                $error("result with nothing owed: status %0d stack_echo %0d entry_data %h",
                       st, echo, data);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            if (st !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, st);
                mismatches++;
            end
            if (echo !== want.echo) begin
                $error("stack_echo: expected %0d, actual %0d", want.echo, echo);
                mismatches++;
            end
            if (data !== want.data) begin
                $error("entry_data: expected %h, actual %h", want.data, data);
                mismatches++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, last);
                mismatches++;
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_cfg_valid  = 1'b0;
    logic [CFG_W-1:0]       i_cfg_data   = '0;
    logic                   start        = 1'b0;
    logic [KIND_W-1:0]      i_kind       = '0;
    logic [ID_W-1:0]        i_stack_id   = '0;
    logic [PORT_DATA_W-1:0] i_payload    = '0;
    logic                   o_cfg_ready;
    logic                   busy;
    logic                   o_valid;
    logic [STATUS_W-1:0]    o_status;
    logic [ID_W-1:0]        o_stack_echo;
    logic [PORT_DATA_W-1:0] o_entry_data;
    logic                   o_last;

    t_stack_mirror mirror = new();
    int            idle_pct = 7;
    int            cycles = 0;

    multi_stack_shared_store_top #(
        .TOTAL_ENTRIES(TOTAL_ENTRIES),
        .MAX_STACKS   (MAX_STACKS),
        .ENTRY_BITS   (ENTRY_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_stack_id  (i_stack_id),
        .i_payload   (i_payload),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_stack_echo(o_stack_echo),
        .o_entry_data(o_entry_data),
        .o_last      (o_last)
    );

    always #6 i_clk = ~i_clk;

    // Check every strobed result at the edge that ends its cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            mirror.check_result(o_status, o_stack_echo, o_entry_data, o_last);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Present one command, hold it until accepted; start stays high for a back-to-back follow-up
    task automatic send_item(t_kind kind, logic [ID_W-1:0] id, logic [PORT_DATA_W-1:0] payload);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_kind     <= kind;
        i_stack_id <= id;
        i_payload  <= payload;
        do @(posedge i_clk); while (busy);
        mirror.note_item(kind, id, payload);
    endtask

    // Wait for every owed result, then let any silent command finish
    task automatic wait_quiet();
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the stack count once the block is idle
    task automatic write_stacks(logic [CFG_W-1:0] value);
        start <= 1'b0;
        wait_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mirror.repartition(value);
    endtask

    initial begin
        int    done;
        int    roll;
        t_kind kind;
        logic [ID_W-1:0] id;

        done = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one stack of ten after reset
        send_item(KIND_POP,  4'd0, '0);
        send_item(KIND_LIST, 4'd0, '1);
        send_item(KIND_PUSH, 4'd0, '1);
        send_item(KIND_PUSH, 4'd0, '0);
        send_item(KIND_LIST, 4'd0, '0);
        send_item(KIND_POP,  4'd0, '1);
        send_item(KIND_POP,  4'd0, '0);
        send_item(KIND_PUSH, 4'd1, 64'h8000_0000_0000_0001);
        send_item(KIND_LIST, 4'd15, '0);
        send_item(KIND_POP,  4'd8, '0);
        send_item(KIND_NOP,  4'd0, 64'h5555_5555_5555_5555);
        send_item(KIND_PUSH, 4'd0, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(KIND_PUSH, 4'd0, 64'h5555_5555_5555_5555);
        for (int i = 0; i < 8; i++)
            send_item(KIND_PUSH, 4'd0, {$urandom, $urandom});
        send_item(KIND_PUSH, 4'd0, '1);
        send_item(KIND_LIST, 4'd0, '0);
        send_item(KIND_POP,  4'd0, '0);

        // Random: one phase per stack setting, mostly legal ids with push-heavy traffic
        foreach (STACK_SETTINGS[p]) begin
            write_stacks(STACK_SETTINGS[p]);
            for (int n = 0; n < PHASE_ITEMS; ) begin
                if (done < 117)      idle_pct = 7;
                else if (done < 234) idle_pct = 57;
                else                 idle_pct = 0;
                roll = $urandom_range(99);
                id = ID_W'($urandom_range(mirror.stack_count - 1, 0));
                if (roll < 3)       kind = KIND_NOP;
                else if (roll < 55) kind = KIND_PUSH;
                else if (roll < 80) kind = KIND_POP;
                else                kind = KIND_LIST;
                if ($urandom_range(99) < 8)
                    id = ID_W'($urandom_range(15, mirror.stack_count));
                send_item(kind, id, {$urandom, $urandom});
                if (kind != KIND_NOP) begin
                    n++;
                    done++;
                end
            end
        end

        // Drain and report
        start <= 1'b0;
        wait_quiet();
        if (mirror.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mss_pkg.sv
hw/rtl/mss_ram.sv
hw/rtl/mss_ctrl.sv
hw/rtl/mss_dp.sv
hw/rtl/multi_stack_shared_store_top.sv
tb/sv/multi_stack_shared_store_top_tb.sv
